// ----- rtl/core/kv_table_insert_update_delete_assert.svh -----
// Assertion macros for the checker module of the key-value table.
`ifndef KV_TABLE_INSERT_UPDATE_DELETE_ASSERT_SVH
`define KV_TABLE_INSERT_UPDATE_DELETE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define KVT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define KVT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/kvt_pkg.sv -----
`timescale 1ns / 1ps

package kvt_pkg;

    // Default sizes of the table.
    localparam int CAPACITY_DEF   = 128;
    localparam int KEY_BITS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 64;

    // Fixed widths of the request and result fields.
    localparam int OPCODE_W = 2;
    localparam int KEY_W    = 64;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 7;
    localparam int COUNT_W  = 8;

    typedef logic [OPCODE_W-1:0] t_opcode;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_opcode OP_INSERT = 2'd0;
    localparam t_opcode OP_UPDATE = 2'd1;
    localparam t_opcode OP_DELETE = 2'd2;

    localparam t_status ST_INSERTED  = 3'd0;
    localparam t_status ST_OVERWROTE = 3'd1;
    localparam t_status ST_UPDATED   = 3'd2;
    localparam t_status ST_DELETED   = 3'd3;
    localparam t_status ST_NOT_FOUND = 3'd4;
    localparam t_status ST_FULL      = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
    } t_sts;

endpackage

// ----- rtl/core/kvt_ctrl.sv -----
`timescale 1ns / 1ps

module kvt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  kvt_pkg::t_sts i_sts,
    output kvt_pkg::t_cmd o_cmd,
    output logic          busy,
    output logic          o_valid
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_COMMIT = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

// ----- rtl/core/kvt_dp.sv -----
`timescale 1ns / 1ps

module kvt_dp #(
    parameter int CAPACITY   = kvt_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = kvt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = kvt_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kvt_pkg::t_cmd                 i_cmd,
    input  logic [kvt_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [kvt_pkg::KEY_W-1:0]     i_key,
    input  logic [kvt_pkg::VALUE_W-1:0]   i_value,
    output kvt_pkg::t_sts                 o_sts,
    output logic [kvt_pkg::STATUS_W-1:0]  o_status,
    output logic [kvt_pkg::SLOT_W-1:0]    o_slot,
    output logic [kvt_pkg::COUNT_W-1:0]   o_entry_count
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // Table storage.
    logic [KEY_BITS-1:0]   r_key_mem   [CAPACITY];
    logic [VALUE_BITS-1:0] r_value_mem [CAPACITY];
    logic [CAPACITY-1:0]   r_valid_marks;
    logic [CW-1:0]         r_used;

    // Latched request.
    kvt_pkg::t_opcode      r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;

    // Search pipeline: read address, registered read data, compare.
    logic [CW-1:0]         r_rd_idx;
    logic [KEY_BITS-1:0]   r_rd_key;
    logic [IW-1:0]         r_cmp_idx;
    logic                  r_cmp_vld;
    logic                  r_found;
    logic [IW-1:0]         r_hit_idx;

    // Result registers.
    kvt_pkg::t_status      r_status;
    logic [kvt_pkg::SLOT_W-1:0]  r_slot;
    logic [kvt_pkg::COUNT_W-1:0] r_count;

    logic                  more;
    logic                  issue;
    logic [IW-1:0]         rd_addr;
    logic                  match;
    logic                  room;

    logic                  key_we;
    logic                  val_we;
    logic                  mark_set;
    logic                  mark_clr;
    logic [IW-1:0]         wr_slot;
    logic                  inc;
    kvt_pkg::t_status      n_status;
    logic [CW-1:0]         n_used;
    logic [31:0]           slot_wide;
    logic [31:0]           count_wide;

    assign more    = (r_used > r_rd_idx);
    assign issue   = i_cmd.scan && !r_found && more;
    assign rd_addr = issue ? r_rd_idx[IW-1:0] : '0;
    assign match   = r_cmp_vld && (r_rd_key == r_key);
    assign room    = (r_used < CW'(CAPACITY));

    // The search ends on the first hit, or once every used slot has been compared.
    assign o_sts.scan_done = r_found || (!more && !r_cmp_vld);

    always_comb begin
        key_we   = 1'b0;
        val_we   = 1'b0;
        mark_set = 1'b0;
        mark_clr = 1'b0;
        wr_slot  = '0;
        inc      = 1'b0;
        n_status = kvt_pkg::ST_NOT_FOUND;
        case (r_op)
            kvt_pkg::OP_INSERT: begin
                if (r_found) begin
                    val_we   = 1'b1;
                    mark_set = 1'b1;
                    wr_slot  = r_hit_idx;
                    n_status = kvt_pkg::ST_OVERWROTE;
                end else if (room) begin
                    key_we   = 1'b1;
                    val_we   = 1'b1;
                    mark_set = 1'b1;
                    wr_slot  = r_used[IW-1:0];
                    inc      = 1'b1;
                    n_status = kvt_pkg::ST_INSERTED;
                end else begin
                    n_status = kvt_pkg::ST_FULL;
                end
            end
            kvt_pkg::OP_UPDATE: begin
                if (r_found) begin
                    val_we   = 1'b1;
                    mark_set = 1'b1;
                    wr_slot  = r_hit_idx;
                    n_status = kvt_pkg::ST_UPDATED;
                end
            end
            kvt_pkg::OP_DELETE: begin
                if (r_found) begin
                    mark_clr = 1'b1;
                    wr_slot  = r_hit_idx;
                    n_status = kvt_pkg::ST_DELETED;
                end
            end
            default: begin
                n_status = kvt_pkg::ST_NOT_FOUND;
            end
        endcase
        n_used     = r_used + CW'(inc);
        slot_wide  = 32'(wr_slot);
        count_wide = 32'(n_used);
    end

    // Key memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && key_we) begin
            r_key_mem[wr_slot] <= r_key;
        end
        r_rd_key <= r_key_mem[rd_addr];
    end

    // Value memory: written only.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && val_we) begin
            r_value_mem[wr_slot] <= r_value;
        end
    end

    // Request latch, search indices and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_key   <= i_key[KEY_BITS-1:0];
            r_value <= i_value[VALUE_BITS-1:0];
        end
        if (issue) begin
            r_cmp_idx <= r_rd_idx[IW-1:0];
        end
        if (match && !r_found) begin
            r_hit_idx <= r_cmp_idx;
        end
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_slot   <= slot_wide[kvt_pkg::SLOT_W-1:0];
            r_count  <= count_wide[kvt_pkg::COUNT_W-1:0];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used        <= '0;
            r_valid_marks <= '0;
            r_rd_idx      <= '0;
            r_cmp_vld     <= 1'b0;
            r_found       <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_rd_idx  <= '0;
                r_cmp_vld <= 1'b0;
                r_found   <= 1'b0;
            end else begin
                r_cmp_vld <= issue;
                if (issue) begin
                    r_rd_idx <= r_rd_idx + CW'(1);
                end
                if (match) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_used <= n_used;
                if (mark_set) begin
                    r_valid_marks[wr_slot] <= 1'b1;
                end else if (mark_clr) begin
                    r_valid_marks[wr_slot] <= 1'b0;
                end
            end
        end
    end

    assign o_status      = r_status;
    assign o_slot        = r_slot;
    assign o_entry_count = r_count;

endmodule

// ----- rtl/core/kv_table_insert_update_delete.sv -----
`timescale 1ns / 1ps

// Channel   | Handshake            | Payload
// ----------+----------------------+-----------------------------------------
// request   | start, busy          | i_opcode, i_key, i_value
// result    | o_valid (one cycle)  | o_status, o_slot, o_entry_count
//
// A request is taken when start is high and busy is low. The time until the next request
// can be taken grows with U, the number of slots in use, or with H when the key is found
// in slot H: the key memory read port compares one stored key per cycle. The result shows
// in the cycle before busy drops.
// Reset is synchronous and active low and empties the table.
// Results cannot be held off; o_valid is high for exactly one cycle per request.

module kv_table_insert_update_delete #(
    parameter int CAPACITY   = kvt_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = kvt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = kvt_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [kvt_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [kvt_pkg::KEY_W-1:0]     i_key,
    input  logic [kvt_pkg::VALUE_W-1:0]   i_value,
    output logic                          o_valid,
    output logic [kvt_pkg::STATUS_W-1:0]  o_status,
    output logic [kvt_pkg::SLOT_W-1:0]    o_slot,
    output logic [kvt_pkg::COUNT_W-1:0]   o_entry_count
);

    kvt_pkg::t_cmd cmd;
    kvt_pkg::t_sts sts;

    kvt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    kvt_dp #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_sts         (sts),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_entry_count (o_entry_count)
    );

endmodule

// ----- rtl/core/kvt_chk.sv -----
`timescale 1ns / 1ps

`include "kv_table_insert_update_delete_assert.svh"

module kvt_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input logic [kvt_pkg::STATUS_W-1:0]  o_status,
    input logic [kvt_pkg::SLOT_W-1:0]    o_slot,
    input logic [kvt_pkg::COUNT_W-1:0]   o_entry_count
);

    // A taken request keeps the block busy in the following cycle.
    `KVT_ASSERT_NXT(a_accept_busy, start && !busy, busy, "request taken but block not busy")

    // A result always closes its request, so the block is free right after it.
    `KVT_ASSERT_NXT(a_result_frees, o_valid, !busy && !o_valid, "block still busy after result")

    // Failed operations report slot zero.
    `KVT_ASSERT_IMP(a_fail_slot, o_valid && (o_status == kvt_pkg::ST_NOT_FOUND || o_status == kvt_pkg::ST_FULL), o_slot == '0, "failed request reports a slot")

    // A new entry lands in the last slot in use.
    `KVT_ASSERT_IMP(a_insert_slot, o_valid && (o_status == kvt_pkg::ST_INSERTED), o_entry_count[kvt_pkg::SLOT_W-1:0] == kvt_pkg::SLOT_W'(o_slot + 1'b1), "inserted slot does not match count")

endmodule

bind kv_table_insert_update_delete kvt_chk u_kvt_chk (.*);
